>>> hdl/mfap_pkg.sv
package mfap_pkg;

	localparam int NV = 64;
	localparam int VW = 6;
	localparam int NW = VW + 1;
	localparam int AW = 2 * VW;
	localparam int MD = NV * NV;
	localparam int CW = 16;
	localparam int RW = CW + 1;
	localparam int FW = 22;
	localparam logic [FW-1:0] FLOW_MAX = {FW{1'b1}};
	localparam logic [NW-1:0] VC_RESET = 7'd64;

	typedef struct packed {
		logic          op;
		logic [VW-1:0] from_vertex;
		logic [VW-1:0] to_vertex;
		logic [CW-1:0] capacity;
		logic [VW-1:0] source;
		logic [VW-1:0] sink;
	} req_t;

	typedef struct packed {
		logic [FW-1:0] total_flow;
		logic          status;
	} rsp_t;

	typedef logic [4:0] cmd_t;

	localparam cmd_t C_NONE       = 5'd0;
	localparam cmd_t C_LOAD       = 5'd1;
	localparam cmd_t C_CLEAR      = 5'd2;
	localparam cmd_t C_START      = 5'd3;
	localparam cmd_t C_COPY       = 5'd4;
	localparam cmd_t C_BFS_INIT   = 5'd5;
	localparam cmd_t C_QREAD      = 5'd6;
	localparam cmd_t C_SCAN_BEGIN = 5'd7;
	localparam cmd_t C_SCAN       = 5'd8;
	localparam cmd_t C_WALK_INIT  = 5'd9;
	localparam cmd_t C_PAR        = 5'd10;
	localparam cmd_t C_FWD        = 5'd11;
	localparam cmd_t C_MIN        = 5'd12;
	localparam cmd_t C_SUB        = 5'd13;
	localparam cmd_t C_ADD        = 5'd14;
	localparam cmd_t C_FINISH     = 5'd15;
	localparam cmd_t C_WALK2      = 5'd16;

	typedef struct packed {
		logic clr_last;
		logic trivial;
		logic copy_done;
		logic scan_done;
		logic q_more;
		logic dst_reached;
		logic walk_at_src;
	} stat_t;

endpackage

>>> hdl/max_flow_augmenting_paths.sv
// channel   ports                     handshake
// item in   start, request            taken when start and not busy
// result    done, result              one cycle strobe, no back pressure
// config    cfg_we, cfg_wdata         written when cfg_we, by user only while idle
//
// a load item is written while busy stays low; the next item may follow at once
// a run item copies the capacity matrix into the residual store, then per search
// scans the row of each dequeued vertex, then walks each path twice to augment it
// after reset a clearing pass zeroes all 4096 capacity entries, busy high
// the block itself leaves config writes unchecked: idle only is the user's rule
module max_flow_augmenting_paths (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  mfap_pkg::req_t           request,
	output logic                     done,
	output mfap_pkg::rsp_t           result,
	input  logic                     cfg_we,
	input  logic [mfap_pkg::NW-1:0]  cfg_wdata
);

	mfap_pkg::cmd_t  cmd;
	mfap_pkg::stat_t stat;

	mfap_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(request.op),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	mfap_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .request(request),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .stat(stat),
		.done(done), .result(result)
	);

endmodule

>>> hdl/mfap_ram.sv
module mfap_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/mfap_dp.sv
module mfap_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mfap_pkg::cmd_t      cmd,
	input  mfap_pkg::req_t      request,
	input  logic                cfg_we,
	input  logic [mfap_pkg::NW-1:0] cfg_wdata,
	output mfap_pkg::stat_t     stat,
	output logic                done,
	output mfap_pkg::rsp_t      result
);

	localparam int NV = mfap_pkg::NV;
	localparam int VW = mfap_pkg::VW;
	localparam int NW = mfap_pkg::NW;
	localparam int AW = mfap_pkg::AW;
	localparam int CW = mfap_pkg::CW;
	localparam int RW = mfap_pkg::RW;
	localparam int FW = mfap_pkg::FW;

	logic [NW-1:0]   vc_q, n_q, n_c;
	logic [VW-1:0]   src_q, dst_q, u_q, walk_q, sv_s1;
	logic            eq_q, oor_q, sval_s1, cp_s1, done_q, status_q;
	logic [AW:0]     cnt_q;
	logic [AW-1:0]   cpa_s1;
	logic [NW-1:0]   v_q, head_q, tail_q;
	logic [mfap_pkg::NV-1:0] vis_q;
	logic [RW-1:0]   step_q;
	logic [FW-1:0]   total_q, flow_q;
	logic [FW:0]     sum_c;

	logic            cap_we, res_we, par_we, q_we, hit;
	logic [AW-1:0]   cap_waddr, res_waddr, res_raddr;
	logic [CW-1:0]   cap_wdata, cap_rdata;
	logic [RW-1:0]   res_wdata, res_rdata;
	logic [VW-1:0]   par_waddr, par_wdata, par_rdata, q_waddr, q_wdata, q_rdata;

	always_comb begin
		if (vc_q < NW'(2)) begin
			n_c = NW'(2);
		end else if (vc_q > NW'(mfap_pkg::NV)) begin
			n_c = NW'(mfap_pkg::NV);
		end else begin
			n_c = vc_q;
		end
	end

	assign hit = sval_s1 && !vis_q[sv_s1] && (res_rdata != '0);
	assign sum_c = {1'b0, total_q} + (FW+1)'(step_q);

	assign cap_we    = (cmd == mfap_pkg::C_LOAD) || (cmd == mfap_pkg::C_CLEAR);
	assign cap_waddr = (cmd == mfap_pkg::C_LOAD) ? {request.from_vertex, request.to_vertex}
		: cnt_q[AW-1:0];
	assign cap_wdata = (cmd == mfap_pkg::C_LOAD) ? request.capacity : '0;

	always_comb begin
		res_we    = 1'b0;
		res_waddr = cpa_s1;
		res_wdata = RW'(cap_rdata);
		res_raddr = '0;
		if (cp_s1) begin
			res_we = 1'b1;
		end
		case (cmd)
			mfap_pkg::C_SCAN: res_raddr = {u_q, v_q[VW-1:0]};
			mfap_pkg::C_FWD:  res_raddr = {par_rdata, walk_q};
			mfap_pkg::C_SUB: begin
				res_we    = 1'b1;
				res_waddr = {u_q, walk_q};
				res_wdata = res_rdata - step_q;
				res_raddr = {walk_q, u_q};
			end
			mfap_pkg::C_ADD: begin
				res_we    = 1'b1;
				res_waddr = {walk_q, u_q};
				res_wdata = res_rdata + step_q;
			end
			default: res_raddr = '0;
		endcase
	end

	always_comb begin
		par_we = 1'b0;
		par_waddr = sv_s1;
		par_wdata = u_q;
		q_we = 1'b0;
		q_waddr = tail_q[VW-1:0];
		q_wdata = sv_s1;
		if (cmd == mfap_pkg::C_BFS_INIT) begin
			par_we = 1'b1;
			par_waddr = src_q;
			par_wdata = src_q;
			q_we = 1'b1;
			q_waddr = '0;
			q_wdata = src_q;
		end else if (hit) begin
			par_we = 1'b1;
			q_we = !tail_q[VW];
		end
	end

	mfap_ram #(.W(CW), .D(mfap_pkg::MD)) u_cap (
		.clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
		.raddr(cnt_q[AW-1:0]), .rdata(cap_rdata)
	);

	mfap_ram #(.W(RW), .D(mfap_pkg::MD)) u_res (
		.clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
		.raddr(res_raddr), .rdata(res_rdata)
	);

	mfap_ram #(.W(VW), .D(mfap_pkg::NV)) u_par (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
		.raddr(walk_q), .rdata(par_rdata)
	);

	mfap_ram #(.W(VW), .D(mfap_pkg::NV)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(head_q[VW-1:0]), .rdata(q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q    <= mfap_pkg::VC_RESET;
			cnt_q   <= '0;
			cp_s1   <= 1'b0;
			sval_s1 <= 1'b0;
			done_q  <= 1'b0;
			vis_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			flow_q  <= '0;
			status_q <= 1'b0;
			total_q <= '0;
		end else begin
			if (cfg_we) begin
				vc_q <= cfg_wdata;
			end
			cp_s1   <= (cmd == mfap_pkg::C_COPY) && !cnt_q[AW];
			cpa_s1  <= cnt_q[AW-1:0];
			sval_s1 <= (cmd == mfap_pkg::C_SCAN) && (v_q < n_q);
			sv_s1   <= v_q[VW-1:0];
			done_q  <= (cmd == mfap_pkg::C_FINISH);
			if (hit) begin
				vis_q[sv_s1] <= 1'b1;
				if (!tail_q[VW]) begin
					tail_q <= tail_q + NW'(1);
				end
			end
			case (cmd)
				mfap_pkg::C_CLEAR: cnt_q <= cnt_q + (AW+1)'(1);
				mfap_pkg::C_START: begin
					src_q   <= request.source;
					dst_q   <= request.sink;
					n_q     <= n_c;
					eq_q    <= request.source == request.sink;
					oor_q   <= (NW'(request.source) >= n_c) || (NW'(request.sink) >= n_c);
					total_q <= '0;
					cnt_q   <= '0;
				end
				mfap_pkg::C_COPY: begin
					if (!cnt_q[AW]) begin
						cnt_q <= cnt_q + (AW+1)'(1);
					end
				end
				mfap_pkg::C_BFS_INIT: begin
					vis_q <= NV'(1) << src_q;
					head_q <= '0;
					tail_q <= NW'(1);
				end
				mfap_pkg::C_QREAD: head_q <= head_q + NW'(1);
				mfap_pkg::C_SCAN_BEGIN: begin
					u_q <= q_rdata;
					v_q <= '0;
				end
				mfap_pkg::C_SCAN: begin
					if (v_q < n_q) begin
						v_q <= v_q + NW'(1);
					end
				end
				mfap_pkg::C_WALK_INIT: begin
					walk_q <= dst_q;
					step_q <= '1;
				end
				mfap_pkg::C_WALK2: begin
					walk_q <= dst_q;
					total_q <= (sum_c > (FW+1)'(mfap_pkg::FLOW_MAX)) ? mfap_pkg::FLOW_MAX
						: sum_c[FW-1:0];
				end
				mfap_pkg::C_FWD: u_q <= par_rdata;
				mfap_pkg::C_MIN: begin
					if (res_rdata < step_q) begin
						step_q <= res_rdata;
					end
					walk_q <= u_q;
				end
				mfap_pkg::C_ADD: walk_q <= u_q;
				mfap_pkg::C_FINISH: begin
					flow_q   <= (eq_q || oor_q) ? '0 : total_q;
					status_q <= eq_q;
				end
				default: ;
			endcase
		end
	end

	assign stat.clr_last    = cnt_q[AW-1:0] == '1;
	assign stat.trivial     = eq_q || oor_q;
	assign stat.copy_done   = cnt_q[AW] && !cp_s1;
	assign stat.scan_done   = (v_q == n_q) && !sval_s1;
	assign stat.q_more      = head_q < tail_q;
	assign stat.dst_reached = vis_q[dst_q];
	assign stat.walk_at_src = walk_q == src_q;

	assign done = done_q;
	assign result.total_flow = flow_q;
	assign result.status = status_q;

endmodule

>>> hdl/mfap_ctrl.sv
module mfap_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            op,
	input  mfap_pkg::stat_t stat,
	output mfap_pkg::cmd_t  cmd,
	output logic            busy
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_START = 4'd2;
	localparam logic [3:0] S_COPY  = 4'd3;
	localparam logic [3:0] S_BFS   = 4'd4;
	localparam logic [3:0] S_CHECK = 4'd5;
	localparam logic [3:0] S_QREAD = 4'd6;
	localparam logic [3:0] S_QWAIT = 4'd7;
	localparam logic [3:0] S_SCAN  = 4'd8;
	localparam logic [3:0] S_MPAR  = 4'd9;
	localparam logic [3:0] S_MFWD  = 4'd10;
	localparam logic [3:0] S_MMIN  = 4'd11;
	localparam logic [3:0] S_UPAR  = 4'd12;
	localparam logic [3:0] S_UFWD  = 4'd13;
	localparam logic [3:0] S_USUB  = 4'd14;
	localparam logic [3:0] S_UADD  = 4'd15;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = mfap_pkg::C_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd = mfap_pkg::C_CLEAR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (op) begin
						cmd = mfap_pkg::C_START;
						state_d = S_START;
					end else begin
						cmd = mfap_pkg::C_LOAD;
					end
				end
			end
			S_START: begin
				if (stat.trivial) begin
					cmd = mfap_pkg::C_FINISH;
					state_d = S_IDLE;
				end else begin
					state_d = S_COPY;
				end
			end
			S_COPY: begin
				cmd = mfap_pkg::C_COPY;
				if (stat.copy_done) state_d = S_BFS;
			end
			S_BFS: begin
				cmd = mfap_pkg::C_BFS_INIT;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.q_more) begin
					state_d = S_QREAD;
				end else if (stat.dst_reached) begin
					cmd = mfap_pkg::C_WALK_INIT;
					state_d = S_MPAR;
				end else begin
					cmd = mfap_pkg::C_FINISH;
					state_d = S_IDLE;
				end
			end
			S_QREAD: begin
				cmd = mfap_pkg::C_QREAD;
				state_d = S_QWAIT;
			end
			S_QWAIT: begin
				cmd = mfap_pkg::C_SCAN_BEGIN;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd = mfap_pkg::C_SCAN;
				if (stat.scan_done) state_d = S_CHECK;
			end
			S_MPAR: begin
				if (stat.walk_at_src) begin
					cmd = mfap_pkg::C_WALK2;
					state_d = S_UPAR;
				end else begin
					cmd = mfap_pkg::C_PAR;
					state_d = S_MFWD;
				end
			end
			S_MFWD: begin
				cmd = mfap_pkg::C_FWD;
				state_d = S_MMIN;
			end
			S_MMIN: begin
				cmd = mfap_pkg::C_MIN;
				state_d = S_MPAR;
			end
			S_UPAR: begin
				if (stat.walk_at_src) begin
					state_d = S_BFS;
				end else begin
					cmd = mfap_pkg::C_PAR;
					state_d = S_UFWD;
				end
			end
			S_UFWD: begin
				cmd = mfap_pkg::C_FWD;
				state_d = S_USUB;
			end
			S_USUB: begin
				cmd = mfap_pkg::C_SUB;
				state_d = S_UADD;
			end
			S_UADD: begin
				cmd = mfap_pkg::C_ADD;
				state_d = S_UPAR;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

>>> verif/tb_max_flow_augmenting_paths.sv
module tb_max_flow_augmenting_paths;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NV = mfap_pkg::NV;
	localparam int VW = mfap_pkg::VW;
	localparam int NW = mfap_pkg::NW;
	localparam int CW = mfap_pkg::CW;
	localparam int FW = mfap_pkg::FW;
	localparam int RQW = $bits(mfap_pkg::req_t);

	class flow_scoreboard;
		logic [CW-1:0] cap_mem [NV][NV];
		longint        resid [NV][NV];
		bit            seen [NV];
		int            parent [NV];
		int            fifo [NV];
		int            active;
		mfap_pkg::rsp_t pending [$];
		int            errors;

		function new();
			foreach (cap_mem[i, j]) cap_mem[i][j] = '0;
			active = NV;
			errors = 0;
		endfunction

		function void set_vertex_count(logic [NW-1:0] v);
			if (v < 2) active = 2;
			else if (v > NV) active = NV;
			else active = int'(v);
		endfunction

		function bit find_path(int s, int d);
			int head;
			int tail;
			int u;
			head = 0;
			tail = 0;
			foreach (seen[i]) seen[i] = 0;
			fifo[tail++] = s;
			seen[s] = 1;
			parent[s] = s;
			while (head < tail) begin
				u = fifo[head++];
				for (int v = 0; v < active; v++) begin
					if (!seen[v] && resid[u][v] > 0) begin
						if (tail < NV) fifo[tail++] = v;
						parent[v] = u;
						seen[v] = 1;
					end
				end
			end
			return seen[d];
		endfunction

		function longint solve_flow(int s, int d);
			longint total;
			longint bottleneck;
			int u;
			total = 0;
			for (int i = 0; i < active; i++)
				for (int j = 0; j < active; j++)
					resid[i][j] = cap_mem[i][j];
			while (find_path(s, d)) begin
				bottleneck = 64'h7fff_ffff_ffff_ffff;
				for (int v = d; v != s; v = parent[v]) begin
					u = parent[v];
					if (resid[u][v] < bottleneck) bottleneck = resid[u][v];
				end
				for (int v = d; v != s; v = parent[v]) begin
					u = parent[v];
					resid[u][v] -= bottleneck;
					resid[v][u] += bottleneck;
				end
				total += bottleneck;
				if (total > mfap_pkg::FLOW_MAX) total = mfap_pkg::FLOW_MAX;
			end
			return total;
		endfunction

		function void note(mfap_pkg::req_t r);
			mfap_pkg::rsp_t e;
			if (r.op == 1'b0) begin
				cap_mem[r.from_vertex][r.to_vertex] = r.capacity;
			end else begin
				e.status = 1'b0;
				e.total_flow = '0;
				if (r.source == r.sink) e.status = 1'b1;
				else if (r.source < active && r.sink < active)
					e.total_flow = FW'(solve_flow(int'(r.source), int'(r.sink)));
				pending.push_back(e);
			end
		endfunction

		function void check(mfap_pkg::rsp_t got);
			mfap_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result total_flow=%0d status=%0d", $time,
					got.total_flow, got.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.total_flow !== e.total_flow) begin
				$display("%0t: total_flow expected %0d actual %0d", $time, e.total_flow,
					got.total_flow);
				errors++;
			end
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	mfap_pkg::req_t request;
	logic           done;
	mfap_pkg::rsp_t result;
	logic           cfg_we;
	logic [NW-1:0]  cfg_wdata;

	flow_scoreboard sb;
	bit             calm;

	max_flow_augmenting_paths i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check(result);
	end

	initial begin
		#40_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_item(mfap_pkg::req_t r);
		while (!calm && $urandom_range(99) < 12) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		request = r;
		while (busy) @(negedge clk);
		@(posedge clk);
		sb.note(r);
	endtask

	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending.size() != 0 || busy) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_vertex_count(logic [NW-1:0] v);
		settle();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_vertex_count(v);
	endtask

	function automatic mfap_pkg::req_t edge_item(int f, int t, int c);
		mfap_pkg::req_t r;
		r = mfap_pkg::req_t'(RQW'($urandom));
		r.op = 1'b0;
		r.from_vertex = VW'(f);
		r.to_vertex = VW'(t);
		r.capacity = CW'(c);
		return r;
	endfunction

	function automatic mfap_pkg::req_t run_item(int s, int d);
		mfap_pkg::req_t r;
		r = mfap_pkg::req_t'(RQW'({$urandom, $urandom}));
		r.op = 1'b1;
		r.source = VW'(s);
		r.sink = VW'(d);
		return r;
	endfunction

	function automatic int pick_capacity();
		case ($urandom_range(3))
			0: return $urandom_range(65535);
			1: return 65535;
			default: return $urandom_range(20);
		endcase
	endfunction

	task automatic random_phase(int count);
		int n;
		int sent;
		n = sb.active;
		sent = 0;
		while (sent < count) begin
			calm = (sent < count / 3);
			if ($urandom_range(9) < 8) begin
				// well-formed graph: a batch of edges then a run
				repeat ($urandom_range(3, 10)) begin
					send_item(edge_item($urandom_range(n - 1), $urandom_range(n - 1),
						pick_capacity()));
					sent++;
				end
				send_item(run_item($urandom_range(n - 1), $urandom_range(n - 1)));
				sent++;
			end else begin
				send_item(mfap_pkg::req_t'(RQW'({$urandom, $urandom})));
				sent++;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		sb = new();
		calm = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, equal end points, unused end points
		write_vertex_count(7'd64);
		send_item(run_item(0, 63));
		send_item(edge_item(0, 63, 65535));
		send_item(edge_item(63, 0, 1));
		send_item(run_item(0, 63));
		send_item(run_item(63, 0));
		send_item(run_item(5, 5));
		send_item(edge_item(0, 1, 7));
		send_item(edge_item(1, 63, 3));
		send_item(run_item(0, 63));
		send_item(edge_item(0, 63, 0));
		send_item(run_item(0, 63));
		write_vertex_count(7'd2);
		send_item(run_item(0, 1));
		send_item(run_item(0, 63));
		send_item(run_item(63, 63));
		send_item(edge_item(0, 1, 65535));
		send_item(edge_item(1, 0, 65535));
		send_item(run_item(1, 0));
		write_vertex_count(7'd127);
		send_item(run_item(0, 63));
		write_vertex_count(7'd0);
		send_item(run_item(0, 1));
		send_item(run_item(0, 2));

		write_vertex_count(7'd8);
		random_phase(100);
		write_vertex_count(7'd1);
		random_phase(30);
		write_vertex_count(7'd5);
		random_phase(90);
		write_vertex_count(7'd100);
		random_phase(40);
		write_vertex_count(7'd12);
		random_phase(90);
		write_vertex_count(7'd64);
		random_phase(30);

		settle();
		repeat (200) @(posedge clk);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
